/* src/pls_pkg.sv */
// Package for the positional list with running balance total.
// Holds the word types, operation and status codes, and cell control types.
// Used by pls_cell and positional_list_with_sum.
package pls_pkg;

  localparam int MaxEntriesDef = 16;
  localparam int PosW = 5;
  localparam int DataW = 32;
  localparam int TotalW = 36;
  localparam int OutCountW = 5;
  localparam int OutIndexW = 4;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LIST = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_INSERT = 2'd1;
  localparam logic [1:0] STATUS_BAD_REMOVE = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [PosW-1:0] position;
    logic signed [DataW-1:0] record_id;
    logic signed [DataW-1:0] balance;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [OutIndexW-1:0] entry_index;
    logic signed [DataW-1:0] entry_id;
    logic signed [DataW-1:0] entry_balance;
    logic [OutCountW-1:0] count;
    logic signed [TotalW-1:0] total;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] id;
    logic signed [DataW-1:0] bal;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

/* src/positional_list_with_sum.sv */
// Top level of the positional list with running balance total.
// Instantiates the chain of pls_cell cells and holds the control and output.
// Depends on pls_pkg and pls_cell.
//
// Usage: one input word carries an insert, remove or list operation on the
// valid/stall input channel. Results leave on the valid/stall output channel
// through a single output register.
// Insert, remove and the unused code each give one result word in the cycle
// after acceptance; a valid insert or remove shifts the cells at and above
// its position. A list of N entries gives N words: the controller enters the
// list state, then one word per cycle while the receiver takes them. The chain
// rotates one place per word and the head cell feeds the output, so the input
// stalls through the list pass and the chain ends in its first order.
// Listing an empty list gives a single empty-status word.
// The block takes one operation at a time: a new word is accepted once the
// list pass is done and the output register is free or being read.
// When the receiver stalls, the output word holds and the chain waits.
// Reset clears the entry count, the total, the controller and the output
// valid. Record storage is not cleared; only entries below the count are
// ever read.
module positional_list_with_sum #(
  parameter int MAX_ENTRIES = pls_pkg::MaxEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pls_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pls_pkg::out_word_t out_word_o
);
  import pls_pkg::*;

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;

  state_e state_q;
  state_e state_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic signed [TotalW-1:0] total_q;
  logic signed [TotalW-1:0] total_d;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] idx_d;
  logic out_valid_q;
  logic out_valid_d;
  out_word_t out_q;
  out_word_t out_d;

  logic accept;
  logic out_free;
  logic list_step;
  logic list_last;
  logic ins_ok;
  logic rem_ok;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] cnt_next_ext;
  logic [CmpW-1:0] idx_ext;
  logic [DataW-1:0] gone_bal;
  cell_ctrl_t ctrl;
  entry_t new_entry;

  entry_t cell_q [MAX_ENTRIES];
  logic [DataW-1:0] hit_bal [MAX_ENTRIES];

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign accept = in_valid_i & ~in_stall_o;

  assign pos_ext = CmpW'(in_word_i.position);
  assign cnt_ext = CmpW'(count_q);
  assign ins_ok = (cnt_ext < CmpW'(MAX_ENTRIES)) && (pos_ext <= cnt_ext);
  assign rem_ok = pos_ext < cnt_ext;
  assign list_last = (idx_q + CntW'(1)) == count_q;
  assign new_entry.id = in_word_i.record_id;
  assign new_entry.bal = in_word_i.balance;

  always_comb begin
    gone_bal = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      gone_bal = gone_bal | hit_bal[k];
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = cell_q[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = cell_q[g+1];
    end
    pls_cell #(
      .Index(g),
      .CntW (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .cnt_i    (count_q),
      .left_i   (left_e),
      .right_i  (right_e),
      .head_i   (cell_q[0]),
      .new_i    (new_entry),
      .q_o      (cell_q[g]),
      .hit_bal_o(hit_bal[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_word_i.func == FUNC_LIST) && (count_q != '0)) begin
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        if (list_step && list_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op = OP_HOLD;
    ctrl.pos = in_word_i.position;
    list_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_word_i.func == FUNC_INSERT) && ins_ok) begin
          ctrl.op = OP_INSERT;
        end else if (accept && (in_word_i.func == FUNC_REMOVE) && rem_ok) begin
          ctrl.op = OP_REMOVE;
        end
      end
      ST_LIST: begin
        list_step = out_free;
        if (out_free) begin
          ctrl.op = OP_ROTATE;
        end
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    case (ctrl.op)
      OP_INSERT: begin
        count_d = count_q + CntW'(1);
        total_d = total_q + TotalW'(in_word_i.balance);
      end
      OP_REMOVE: begin
        count_d = count_q - CntW'(1);
        total_d = total_q - TotalW'($signed(gone_bal));
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign cnt_next_ext = CmpW'(count_d);
  assign idx_ext = CmpW'(idx_q);

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d = out_q;
    idx_d = idx_q;
    if (accept) begin
      idx_d = '0;
      out_d.entry_index = '0;
      out_d.entry_id = '0;
      out_d.entry_balance = '0;
      out_d.count = cnt_next_ext[OutCountW-1:0];
      out_d.total = total_d;
      out_d.last = 1'b1;
      out_d.status = STATUS_OK;
      out_valid_d = 1'b1;
      case (in_word_i.func)
        FUNC_INSERT: begin
          if (!ins_ok) begin
            out_d.status = STATUS_BAD_INSERT;
          end
        end
        FUNC_REMOVE: begin
          if (!rem_ok) begin
            out_d.status = STATUS_BAD_REMOVE;
          end
        end
        FUNC_LIST: begin
          if (count_q == '0) begin
            out_d.status = STATUS_EMPTY;
          end else begin
            out_valid_d = 1'b0;
          end
        end
        default: begin
          out_d.status = STATUS_OK;
        end
      endcase
    end else if (list_step) begin
      out_valid_d = 1'b1;
      out_d.status = STATUS_OK;
      out_d.entry_index = idx_ext[OutIndexW-1:0];
      out_d.entry_id = cell_q[0].id;
      out_d.entry_balance = cell_q[0].bal;
      out_d.count = cnt_ext[OutCountW-1:0];
      out_d.total = total_q;
      out_d.last = list_last;
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      total_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;

endmodule

/* src/pls_cell.sv */
// One cell of the list chain: holds a single record and takes its next value
// from itself, a neighbor, the head cell or the new record.
// Depends on pls_pkg.
module pls_cell #(
  parameter int Index = 0,
  parameter int CntW = 5
) (
  input  logic                      clk_i,
  input  pls_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CntW-1:0]           cnt_i,
  input  pls_pkg::entry_t           left_i,
  input  pls_pkg::entry_t           right_i,
  input  pls_pkg::entry_t           head_i,
  input  pls_pkg::entry_t           new_i,
  output pls_pkg::entry_t           q_o,
  output logic [pls_pkg::DataW-1:0] hit_bal_o
);
  import pls_pkg::*;

  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] MyIdx = CmpW'(Index);

  entry_t entry_q;
  entry_t entry_d;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;

  assign pos_ext = CmpW'(ctrl_i.pos);
  assign cnt_ext = CmpW'(cnt_i);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (MyIdx == pos_ext) begin
          entry_d = new_i;
        end else if (MyIdx > pos_ext) begin
          entry_d = left_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_ext) begin
          entry_d = right_i;
        end
      end
      OP_ROTATE: begin
        if (MyIdx + CmpW'(1) == cnt_ext) begin
          entry_d = head_i;
        end else if (MyIdx + CmpW'(1) < cnt_ext) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;
  assign hit_bal_o = (MyIdx == pos_ext) ? entry_q.bal : '0;

endmodule
